// ===== rtl/core/synced_seconds_clock_defines.svh =====
// Assertion macros for the synced seconds clock checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SYNCED_SECONDS_CLOCK_DEFINES_SVH
`define SYNCED_SECONDS_CLOCK_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssc checker: implication failed");

// next-cycle implication, off while reset is held
`define SSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssc checker: next-cycle check failed");

// next-cycle implication that also runs through reset
`define SSC_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ssc checker: reset check failed");

`endif

// ===== rtl/core/ssc_pkg.sv =====
// Shared types and constants of the synced seconds clock.
// No dependencies; used by ssc_core, the top level and the checker.
package ssc_pkg;

    // action codes of an input word
    localparam logic [2:0] ACT_BASE_TICK = 3'd0;
    localparam logic [2:0] ACT_PERIODIC  = 3'd1;
    localparam logic [2:0] ACT_SYNC      = 3'd2;
    localparam logic [2:0] ACT_SET_TIME  = 3'd3;
    localparam logic [2:0] ACT_SET_TICKS = 3'd4;
    localparam logic [2:0] ACT_ADD_DCF   = 3'd5;
    localparam logic [2:0] ACT_ADD_NTP   = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_TICKS_PER_SEC = 3'd0;
    localparam logic [2:0] CFG_RESYNC_PERIOD = 3'd1;
    localparam logic [2:0] CFG_RETRY_PERIOD  = 3'd2;
    localparam logic [2:0] CFG_BACK_STEP_LIM = 3'd3;
    localparam logic [2:0] CFG_SYNC_GATE_EN  = 3'd4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register reset values
    localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd50;
    localparam logic [15:0] RST_RESYNC_PERIOD = 16'd3600;
    localparam logic [15:0] RST_RETRY_PERIOD  = 16'd10;
    localparam logic [15:0] RST_BACK_STEP_LIM = 16'd300;
    localparam logic        RST_SYNC_GATE_EN  = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] time_value;
        logic [7:0]  tick_value;
        logic [15:0] count_value;
        logic [7:0]  capture_count;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        current_time;
        logic [7:0]         subsecond_ticks;
        logic [31:0]        uptime_seconds;
        logic [31:0]        last_sync_time;
        logic [7:0]         last_sync_capture;
        logic signed [15:0] last_delta;
        logic [15:0]        sync_countdown;
        logic [15:0]        dcf_total;
        logic [15:0]        ntp_total;
        logic               send_request;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  ticks_per_second;
        logic [15:0] resync_period;
        logic [15:0] retry_period;
        logic [15:0] back_step_limit;
        logic        sync_gate_enable;
    } t_cfg;

endpackage

// ===== rtl/core/ssc_core.sv =====
// Clock state registers and the one-pass update for a single word.
// Depends on ssc_pkg (word and configuration types, action codes).
module ssc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ssc_pkg::t_in_word i_word,
    input  ssc_pkg::t_cfg     i_cfg,
    output ssc_pkg::t_out_word o_result
);

    logic [TIME_BITS-1:0] r_time, r_uptime, r_shadow, r_record;
    logic [TIME_BITS-1:0] n_time, n_uptime, n_shadow, n_record;
    logic [7:0]           r_tick, n_tick, r_capture, n_capture;
    logic [15:0]          r_delta, n_delta, r_countdown, n_countdown;
    logic [15:0]          r_dcf, n_dcf, r_ntp, n_ntp;
    logic                 n_send;

    logic [TIME_BITS-1:0] t_new;
    logic [7:0]           tick_inc;
    logic                 sec_end, sec_adv, step_ok;

    assign t_new    = TIME_BITS'(i_word.time_value);
    assign tick_inc = r_tick + 8'd1;
    assign sec_end  = tick_inc >= i_cfg.ticks_per_second;
    // time moves on unless held waiting for the shadow to catch up
    assign sec_adv  = !i_cfg.sync_gate_enable || (r_shadow == '0) || (r_shadow == r_time);
    // forward always, backward only when more than the limit ahead
    assign step_ok  = (t_new > r_time)
                   || ((r_time - t_new) > TIME_BITS'(i_cfg.back_step_limit));

    always_comb begin
        n_time      = r_time;
        n_uptime    = r_uptime;
        n_shadow    = r_shadow;
        n_record    = r_record;
        n_tick      = r_tick;
        n_capture   = r_capture;
        n_delta     = r_delta;
        n_countdown = r_countdown;
        n_dcf       = r_dcf;
        n_ntp       = r_ntp;
        n_send      = 1'b0;
        unique case (i_word.action)
            ssc_pkg::ACT_BASE_TICK: begin
                n_tick = tick_inc;
                if (sec_end) begin
                    n_tick = 8'd0;
                    if (sec_adv) begin
                        n_time   = r_time + TIME_BITS'(1);
                        n_uptime = r_uptime + TIME_BITS'(1);
                    end
                    if (r_shadow != '0) begin
                        n_shadow = r_shadow + TIME_BITS'(1);
                    end
                end
            end
            ssc_pkg::ACT_PERIODIC: begin
                if (r_countdown != 16'd0) begin
                    n_countdown = r_countdown - 16'd1;
                end else begin
                    n_countdown = i_cfg.retry_period;
                    n_send      = 1'b1;
                end
            end
            ssc_pkg::ACT_SYNC: begin
                if (r_shadow != '0) begin
                    n_delta = 16'(t_new - r_shadow);
                end
                n_shadow    = t_new;
                n_record    = t_new;
                n_capture   = i_word.capture_count;
                n_countdown = i_cfg.resync_period;
                if (step_ok) begin
                    n_time = t_new;
                end
            end
            ssc_pkg::ACT_SET_TIME: begin
                n_time = t_new;
            end
            ssc_pkg::ACT_SET_TICKS: begin
                n_time = t_new;
                n_tick = i_word.tick_value;
            end
            ssc_pkg::ACT_ADD_DCF: begin
                n_dcf = (i_word.count_value == 16'd0) ? 16'd0 : r_dcf + i_word.count_value;
            end
            ssc_pkg::ACT_ADD_NTP: begin
                n_ntp = (i_word.count_value == 16'd0) ? 16'd0 : r_ntp + i_word.count_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_uptime    <= '0;
            r_shadow    <= '0;
            r_record    <= '0;
            r_tick      <= 8'd0;
            r_capture   <= 8'd0;
            r_delta     <= 16'd0;
            r_countdown <= 16'd1;
            r_dcf       <= 16'd0;
            r_ntp       <= 16'd0;
        end else if (i_fire) begin
            r_time      <= n_time;
            r_uptime    <= n_uptime;
            r_shadow    <= n_shadow;
            r_record    <= n_record;
            r_tick      <= n_tick;
            r_capture   <= n_capture;
            r_delta     <= n_delta;
            r_countdown <= n_countdown;
            r_dcf       <= n_dcf;
            r_ntp       <= n_ntp;
        end
    end

    always_comb begin
        o_result.current_time      = 32'(n_time);
        o_result.subsecond_ticks   = n_tick;
        o_result.uptime_seconds    = 32'(n_uptime);
        o_result.last_sync_time    = 32'(n_record);
        o_result.last_sync_capture = n_capture;
        o_result.last_delta        = n_delta;
        o_result.sync_countdown    = n_countdown;
        o_result.dcf_total         = n_dcf;
        o_result.ntp_total         = n_ntp;
        o_result.send_request      = n_send;
    end

endmodule

// ===== rtl/core/synced_seconds_clock.sv =====
// Top level of the synced seconds clock: handshakes, config registers, result register.
// Depends on ssc_pkg and ssc_core.
//
//   channel   direction  handshake                    word
//   in        input      i_in_valid / o_in_stall      ssc_pkg::t_in_word
//   out       output     o_out_valid / i_out_stall    ssc_pkg::t_out_word
//   cfg       input      i_cfg_we (no stall)          i_cfg_index, i_cfg_data
//
// One word a cycle in and out while the output is not stalled; a word passes
// the input register, then the single update pass into the result register.
// Throughput is set by the state update in ssc_core, which feeds straight back on itself.
// Reset is synchronous, active low; it clears the valids, the clock state
// and loads the config defaults. o_in_stall is high during reset.
// A stalled result holds; the input register still takes one more word.
module synced_seconds_clock #(
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ssc_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ssc_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic               r_in_valid, n_in_valid;
    ssc_pkg::t_in_word  r_in_word;
    logic               r_out_valid, n_out_valid;
    ssc_pkg::t_out_word r_out_word;
    ssc_pkg::t_out_word result;
    ssc_pkg::t_cfg      r_cfg, n_cfg;
    logic               adv, in_acc;

    // the held word moves on when the result register is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !adv);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_acc ? 1'b1 : (adv ? 1'b0 : r_in_valid);
    assign n_out_valid = adv ? 1'b1 : (r_out_valid && i_out_stall);

    // config write: indexes past the list are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssc_pkg::CFG_TICKS_PER_SEC: n_cfg.ticks_per_second = i_cfg_data[7:0];
                ssc_pkg::CFG_RESYNC_PERIOD: n_cfg.resync_period    = i_cfg_data;
                ssc_pkg::CFG_RETRY_PERIOD:  n_cfg.retry_period     = i_cfg_data;
                ssc_pkg::CFG_BACK_STEP_LIM: n_cfg.back_step_limit  = i_cfg_data;
                ssc_pkg::CFG_SYNC_GATE_EN:  n_cfg.sync_gate_enable = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_cfg.ticks_per_second <= ssc_pkg::RST_TICKS_PER_SEC;
            r_cfg.resync_period    <= ssc_pkg::RST_RESYNC_PERIOD;
            r_cfg.retry_period     <= ssc_pkg::RST_RETRY_PERIOD;
            r_cfg.back_step_limit  <= ssc_pkg::RST_BACK_STEP_LIM;
            r_cfg.sync_gate_enable <= ssc_pkg::RST_SYNC_GATE_EN;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_word <= i_in_word;
        end
        if (adv) begin
            r_out_word <= result;
        end
    end

    ssc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_word   (r_in_word),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/ssc_checker.sv =====
// Port-level checks on the synced seconds clock, bound to the top level.
// Depends on ssc_pkg and synced_seconds_clock_defines.svh.
`include "synced_seconds_clock_defines.svh"

module ssc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ssc_pkg::t_out_word o_out_word
);

    // a stalled result word stays put
    `SSC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // input only backs up when the result side is full and stalled
    `SSC_ASSERT_IMP(a_stall_full, o_in_stall, o_out_valid && i_out_stall)

    // a word taken in is followed by a valid word at the output
    `SSC_ASSERT_NXT(a_latency, $past(i_in_valid && !o_in_stall), o_out_valid)

    // reset empties the result register
    `SSC_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

bind synced_seconds_clock ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== test/ssc_scoreboard_pkg.sv =====
// Scoreboard class for the synced seconds clock: a cycle-free model of the clock
// state plus the queue of predicted result words. Depends on ssc_pkg.
package ssc_scoreboard_pkg;

    class ssc_clock_scoreboard;

        // register copies
        logic [7:0]  ticks_per_sec;
        logic [15:0] resync_period;
        logic [15:0] retry_period;
        logic [15:0] back_step_limit;
        logic        gate_enable;

        // clock state
        logic [31:0] now_seconds;
        logic [7:0]  tick_count;
        logic [31:0] uptime;
        logic [31:0] sync_shadow;
        logic [31:0] sync_time;
        logic [7:0]  sync_capture;
        logic [15:0] delta;
        logic [15:0] countdown;
        logic [15:0] dcf_sum;
        logic [15:0] ntp_sum;

        ssc_pkg::t_out_word predicted_states[$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            ticks_per_sec   = ssc_pkg::RST_TICKS_PER_SEC;
            resync_period   = ssc_pkg::RST_RESYNC_PERIOD;
            retry_period    = ssc_pkg::RST_RETRY_PERIOD;
            back_step_limit = ssc_pkg::RST_BACK_STEP_LIM;
            gate_enable     = ssc_pkg::RST_SYNC_GATE_EN;
            now_seconds     = '0;
            tick_count      = '0;
            uptime          = '0;
            sync_shadow     = '0;
            sync_time       = '0;
            sync_capture    = '0;
            delta           = '0;
            countdown       = 16'd1;
            dcf_sum         = '0;
            ntp_sum         = '0;
            mismatches      = 0;
            checked         = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] data);
            case (index)
                ssc_pkg::CFG_TICKS_PER_SEC: ticks_per_sec   = data[7:0];
                ssc_pkg::CFG_RESYNC_PERIOD: resync_period   = data;
                ssc_pkg::CFG_RETRY_PERIOD:  retry_period    = data;
                ssc_pkg::CFG_BACK_STEP_LIM: back_step_limit = data;
                ssc_pkg::CFG_SYNC_GATE_EN:  gate_enable     = data[0];
                default: ;
            endcase
        endfunction

        // advance the clock by one accepted word and queue the resulting state
        function void take_word(ssc_pkg::t_in_word w);
            ssc_pkg::t_out_word snap;
            logic [31:0]        behind;
            logic               send;
            send = 1'b0;
            case (w.action)
                ssc_pkg::ACT_BASE_TICK: begin
                    tick_count = tick_count + 8'd1;
                    if (tick_count >= ticks_per_sec) begin
                        // gate compares the shadow before it moves on
                        if (!gate_enable || sync_shadow == '0 || sync_shadow == now_seconds) begin
                            now_seconds = now_seconds + 32'd1;
                            uptime      = uptime + 32'd1;
                        end
                        if (sync_shadow != '0)
                            sync_shadow = sync_shadow + 32'd1;
                        tick_count = '0;
                    end
                end
                ssc_pkg::ACT_PERIODIC: begin
                    if (countdown != '0) begin
                        countdown = countdown - 16'd1;
                    end else begin
                        countdown = retry_period;
                        send      = 1'b1;
                    end
                end
                ssc_pkg::ACT_SYNC: begin
                    if (sync_shadow != '0)
                        delta = w.time_value[15:0] - sync_shadow[15:0];
                    sync_shadow  = w.time_value;
                    sync_time    = w.time_value;
                    sync_capture = w.capture_count;
                    behind       = now_seconds - w.time_value;
                    if (w.time_value > now_seconds || behind > {16'd0, back_step_limit})
                        now_seconds = w.time_value;
                    countdown = resync_period;
                end
                ssc_pkg::ACT_SET_TIME:  now_seconds = w.time_value;
                ssc_pkg::ACT_SET_TICKS: begin
                    now_seconds = w.time_value;
                    tick_count  = w.tick_value;
                end
                ssc_pkg::ACT_ADD_DCF: begin
                    dcf_sum = (w.count_value == '0) ? '0 : dcf_sum + w.count_value;
                end
                ssc_pkg::ACT_ADD_NTP: begin
                    ntp_sum = (w.count_value == '0) ? '0 : ntp_sum + w.count_value;
                end
                default: ;
            endcase
            snap.current_time      = now_seconds;
            snap.subsecond_ticks   = tick_count;
            snap.uptime_seconds    = uptime;
            snap.last_sync_time    = sync_time;
            snap.last_sync_capture = sync_capture;
            snap.last_delta        = delta;
            snap.sync_countdown    = countdown;
            snap.dcf_total         = dcf_sum;
            snap.ntp_total         = ntp_sum;
            snap.send_request      = send;
            predicted_states.push_back(snap);
        endfunction

        function int unsigned pending();
            return predicted_states.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("error: result word %0d, %s: got %h want %h", checked, what, got, want);
            mismatches++;
        endtask

        task check_word(ssc_pkg::t_out_word got);
            ssc_pkg::t_out_word want;
            if (predicted_states.size() == 0) begin
                report_mismatch("word with nothing predicted", got.current_time, '0);
                return;
            end
            want = predicted_states.pop_front();
            if (got.current_time !== want.current_time)
                report_mismatch("current_time", got.current_time, want.current_time);
            if (got.subsecond_ticks !== want.subsecond_ticks)
                report_mismatch("subsecond_ticks", got.subsecond_ticks, want.subsecond_ticks);
            if (got.uptime_seconds !== want.uptime_seconds)
                report_mismatch("uptime_seconds", got.uptime_seconds, want.uptime_seconds);
            if (got.last_sync_time !== want.last_sync_time)
                report_mismatch("last_sync_time", got.last_sync_time, want.last_sync_time);
            if (got.last_sync_capture !== want.last_sync_capture)
                report_mismatch("last_sync_capture", got.last_sync_capture,
                                want.last_sync_capture);
            if (got.last_delta !== want.last_delta)
                report_mismatch("last_delta", got.last_delta, want.last_delta);
            if (got.sync_countdown !== want.sync_countdown)
                report_mismatch("sync_countdown", got.sync_countdown, want.sync_countdown);
            if (got.dcf_total !== want.dcf_total)
                report_mismatch("dcf_total", got.dcf_total, want.dcf_total);
            if (got.ntp_total !== want.ntp_total)
                report_mismatch("ntp_total", got.ntp_total, want.ntp_total);
            if (got.send_request !== want.send_request)
                report_mismatch("send_request", got.send_request, want.send_request);
            checked++;
        endtask

    endclass

endpackage

// ===== test/synced_seconds_clock_test.sv =====
// Self-checking bench for synced_seconds_clock: directed words, then random
// phases under varied settings and idling. Depends on ssc_pkg and ssc_scoreboard_pkg.
module synced_seconds_clock_test;

    // action code the block must ignore
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_WORDS  = 200;
    localparam int          PHASES       = 5;
    localparam int          SETTLE_TICKS = 8;   // wait after the queue empties before the block counts as idle

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    ssc_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ssc_pkg::t_out_word out_word;
    logic               cfg_we    = 1'b0;
    logic [ssc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [ssc_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    ssc_scoreboard_pkg::ssc_clock_scoreboard sb = new();

    int unsigned cycles         = 0;
    int unsigned words_in       = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    synced_seconds_clock u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
    end

    // Receiver: stall decided at each rising edge, held for the whole cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Everything driven at the rising edge has settled by the falling edge, so
    // a word seen valid and unstalled here is taken at the next rising edge.
    always @(negedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            sb.check_word(out_word);
    end

    // Watchdog: a correct run finishes far inside this.
    initial begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words still due", cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic ssc_pkg::t_in_word make_word(logic [2:0] action, logic [31:0] seconds,
                                                    logic [7:0] ticks, logic [15:0] count,
                                                    logic [7:0] capture);
        ssc_pkg::t_in_word w;
        w.action        = action;
        w.time_value    = seconds;
        w.tick_value    = ticks;
        w.count_value   = count;
        w.capture_count = capture;
        return w;
    endfunction

    // Random word, steered by the predicted clock so that syncs land near
    // the time, behind it within and beyond the step-back limit, and so on.
    function automatic ssc_pkg::t_in_word random_word();
        ssc_pkg::t_in_word w;
        int unsigned       pick;
        w.time_value    = $urandom;
        w.tick_value    = 8'($urandom);
        w.count_value   = 16'($urandom);
        w.capture_count = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            w.action = ssc_pkg::ACT_BASE_TICK;
        end else if (pick < 60) begin
            w.action = ssc_pkg::ACT_PERIODIC;
        end else if (pick < 72) begin
            w.action = ssc_pkg::ACT_SYNC;
            case ($urandom_range(6))
                0: w.time_value = '0;
                1: w.time_value = sb.now_seconds + $urandom_range(20);
                2: w.time_value = sb.now_seconds - $urandom_range(20);
                3: w.time_value = sb.now_seconds - sb.back_step_limit - $urandom_range(2);
                4: w.time_value = sb.sync_shadow + $urandom_range(40) - 20;
                default: ;
            endcase
        end else if (pick < 78) begin
            w.action = ssc_pkg::ACT_SET_TIME;
            if ($urandom_range(3) == 0)
                w.time_value = 32'hFFFF_FFFF - $urandom_range(4);
        end else if (pick < 84) begin
            w.action = ssc_pkg::ACT_SET_TICKS;
            case ($urandom_range(3))
                0: w.tick_value = sb.ticks_per_sec - 8'd1;
                1: w.tick_value = 8'hFF;
                default: ;
            endcase
            if ($urandom_range(3) == 0)
                w.time_value = sb.now_seconds;
        end else if (pick < 96) begin
            w.action = (pick < 90) ? ssc_pkg::ACT_ADD_DCF : ssc_pkg::ACT_ADD_NTP;
            case ($urandom_range(4))
                0: w.count_value = '0;
                1: w.count_value = 16'hFFFF;
                default: ;
            endcase
        end else begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    // Sender: random gap, then hold the word until it is taken.
    task automatic push(input ssc_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge clk); while (in_stall !== 1'b0);
        @(posedge clk);
        sb.take_word(w);
        words_in++;
    endtask

    // Only called once the block is idle.
    task automatic write_register(input logic [2:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(index, data);
    endtask

    task automatic load_settings(input logic [7:0] tps, input logic [15:0] resync,
                                 input logic [15:0] retry, input logic [15:0] limit,
                                 input logic gate);
        write_register(ssc_pkg::CFG_TICKS_PER_SEC, {8'd0, tps});
        write_register(ssc_pkg::CFG_RESYNC_PERIOD, resync);
        write_register(ssc_pkg::CFG_RETRY_PERIOD, retry);
        write_register(ssc_pkg::CFG_BACK_STEP_LIM, limit);
        write_register(ssc_pkg::CFG_SYNC_GATE_EN, {15'd0, gate});
        cfg_we <= 1'b0;
    endtask

    // Every word gives a result, so an empty queue plus a short settle is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    initial begin
        ssc_pkg::t_in_word w;
        int unsigned       counted;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings (50 ticks, limit 300, gate on).
        push(make_word(ssc_pkg::ACT_BASE_TICK, '0, '0, '0, '0));
        push(make_word(ssc_pkg::ACT_PERIODIC, '0, '0, '0, '0));   // countdown 1 -> 0
        push(make_word(ssc_pkg::ACT_PERIODIC, '0, '0, '0, '0));   // send, reload retry
        push(make_word(ACT_UNUSED, '1, '1, '1, '1));              // ignored code
        push(make_word(ssc_pkg::ACT_SET_TICKS, 32'hFFFF_FFFF, 8'hFF, '1, '1));
        push(make_word(ssc_pkg::ACT_BASE_TICK, '0, '0, '0, '0));  // ticks wrap, no second
        push(make_word(ssc_pkg::ACT_SET_TICKS, 32'hFFFF_FFFE, 8'd49, '0, '0));
        push(make_word(ssc_pkg::ACT_BASE_TICK, '0, '0, '0, '0));  // second ends, unsynced
        push(make_word(ssc_pkg::ACT_SET_TICKS, 32'hFFFF_FFFF, 8'd49, '0, '0));
        push(make_word(ssc_pkg::ACT_BASE_TICK, '0, '0, '0, '0));  // time wraps to zero
        push(make_word(ssc_pkg::ACT_SYNC, 32'd100, '0, '0, 8'hFF)); // first sync, delta kept
        push(make_word(ssc_pkg::ACT_SYNC, 32'd90, '0, '0, '0));   // behind within limit
        push(make_word(ssc_pkg::ACT_SET_TICKS, 32'd100, 8'd49, '0, '0));
        push(make_word(ssc_pkg::ACT_BASE_TICK, '0, '0, '0, '0));  // gated: time holds
        push(make_word(ssc_pkg::ACT_SYNC, '0, '0, '0, 8'h5A));    // sync with zero clears the shadow, time holds
        push(make_word(ssc_pkg::ACT_SET_TIME, 32'd1000000, '0, '0, '0));
        push(make_word(ssc_pkg::ACT_SYNC, 32'd5, '0, '0, '0));    // beyond limit: step back
        push(make_word(ssc_pkg::ACT_ADD_DCF, '0, '0, 16'hFFFF, '0));
        push(make_word(ssc_pkg::ACT_ADD_DCF, '0, '0, 16'd2, '0)); // wraps
        push(make_word(ssc_pkg::ACT_ADD_DCF, '0, '0, '0, '0));    // clears
        push(make_word(ssc_pkg::ACT_ADD_NTP, '0, '0, 16'hFFFF, '0));
        push(make_word(ssc_pkg::ACT_ADD_NTP, '0, '0, 16'd3, '0));
        push(make_word(ssc_pkg::ACT_ADD_NTP, '1, '1, '0, '1));
        push(make_word(ssc_pkg::ACT_PERIODIC, '1, '1, '1, '1));
        drain();

        // Random phases, each under its own settings and idling mix.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    load_settings(8'd3, 16'd5, 16'd2, 16'd10, 1'b1);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    load_settings(8'd1, 16'd0, 16'd0, 16'd0, 1'b0);
                    send_idle_pct = 54; recv_stall_pct = 0;
                end
                2: begin
                    load_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                    send_idle_pct = 0;  recv_stall_pct = 54;
                end
                3: begin
                    // zero ticks per second: every base tick ends a second
                    load_settings(8'd0, 16'($urandom), 16'($urandom_range(20)),
                                  16'($urandom), 1'b1);
                    send_idle_pct = 10; recv_stall_pct = 10;
                end
                default: begin
                    load_settings(8'(2 + $urandom_range(6)), 16'($urandom_range(50)),
                                  16'($urandom_range(5)), 16'($urandom_range(30)),
                                  1'($urandom_range(1)));
                    send_idle_pct = 10; recv_stall_pct = 10;
                end
            endcase
            counted = 0;
            while (counted < PHASE_WORDS) begin
                w = random_word();
                push(w);
                if (w.action != ACT_UNUSED)
                    counted++;
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report_mismatch("result words never produced", sb.pending(), '0);
        $display("Sent %0d input words and checked %0d result words in %0d cycles.",
                 words_in, sb.checked, cycles);
        $display("Phases ran zero to full-scale settings, gate on and off, idle and stalled.");
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
